/* hw/rtl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_CONTAINS   = 3'd4,
    K_REMOVE     = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [WORD_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/bdq_req_if.sv */
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: one deque operation per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [KIND_W-1:0]     kind;
  logic signed [WORD_WIDTH-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bdq_rsp_if.sv */
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: status and deque view after each request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdq_rsp_if import bdq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [STATUS_W-1:0]   status;
  logic                         found;
  logic        [COUNT_W-1:0]    entry_count;
  logic signed [WORD_WIDTH-1:0] front_value;
  logic signed [WORD_WIDTH-1:0] back_value;

  modport source (output valid, output status, output found, output entry_count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input found, input entry_count,
                  input front_value, input back_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded deque of signed words with membership test and first-match removal.
//
// Usage:
//   req carries one operation per request (kind, value); rsp returns one
//   response per request with status, found flag, entry count and the front
//   and back words after the operation (zero when empty).
//   Each slot is a cell in a row; all cells compare against the request value
//   at once and shift left or right together, so every operation finishes in
//   the cycle it is accepted.
//   The response is registered and valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while the receiver keeps rsp.ready high;
//   the first-match search is a carry chain through the row of cells.
//   The response is held in registers and the deque state; a new request is
//   taken in the same cycle the pending response is taken.
//   When the receiver stalls, req.ready drops and the deque holds its state.
//   Reset (rst, synchronous) empties the deque and drops rsp.valid; stored
//   words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search import bdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  bdq_req_if.sink    req,
  bdq_rsp_if.source  rsp
);

  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  logic                  rsp_valid;
  status_t               status;
  status_t               status_next;
  logic                  found;
  logic                  found_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  found_any;
  logic [COUNT_W-1:0]    last_pos;
  cell_ctrl_t            ctrl;
  logic [WORD_WIDTH-1:0] words [CAPACITY];
  logic                  hits  [CAPACITY+1];

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == COUNT_W'(CAPACITY));
  assign empty     = (count == '0);

  // row of cells with the first-match chain
  assign hits[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;

    if (i == 0) begin : g_head
      assign left_word = ctrl.value;
    end else begin : g_inner_l
      assign left_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_word = words[i];
    end else begin : g_inner_r
      assign right_word = words[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (COUNT_W'(i) < count),
      .tail       (COUNT_W'(i) == count),
      .left_word  (left_word),
      .right_word (right_word),
      .hit_in     (hits[i]),
      .word       (words[i]),
      .hit_out    (hits[i+1])
    );
  end

  assign found_any = hits[CAPACITY];

  // decode request
  always_comb begin
    ctrl.value  = req.value;
    ctrl.cmd    = CMD_NONE;
    count_next  = count;
    status_next = ST_OK;
    found_next  = 1'b0;
    case (req.kind)
      K_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ctrl.cmd   = CMD_PUSH_FRONT;
          count_next = count + 1'b1;
        end
      end
      K_PUSH_BACK: begin
        if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          ctrl.cmd   = CMD_PUSH_BACK;
          count_next = count + 1'b1;
        end
      end
      K_POP_FRONT: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          ctrl.cmd   = CMD_POP_FRONT;
          count_next = count - 1'b1;
        end
      end
      K_POP_BACK: begin
        if (empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          count_next = count - 1'b1;
        end
      end
      K_CONTAINS: begin
        found_next = found_any;
      end
      K_REMOVE: begin
        if (found_any) begin
          ctrl.cmd   = CMD_REMOVE;
          count_next = count - 1'b1;
          found_next = 1'b1;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      ctrl.cmd = CMD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
      status    <= ST_OK;
      found     <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        status    <= status_next;
        found     <= found_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response view comes straight from the deque state
  assign last_pos        = count - 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = status;
  assign rsp.found       = found;
  assign rsp.entry_count = count;
  assign rsp.front_value = empty ? '0 : words[0];
  assign rsp.back_value  = empty ? '0 : words[last_pos[IDX_W-1:0]];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.kind == K_PUSH_FRONT || req.kind == K_PUSH_BACK)
    |=> status == ST_OVERFLOW && $stable(count))
    else $error("push on full deque changed state");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    accept && !empty && (req.kind == K_POP_FRONT || req.kind == K_POP_BACK)
    |=> count == $past(count) - 1'b1)
    else $error("pop did not drop count by one");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && found |-> status == ST_OK)
    else $error("found flag with error status");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> $stable(count) && rsp_valid)
    else $error("state moved while response stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bdq_cell.sv */
// ----------------------------------------------------------------------------
// bdq_cell
// One deque slot: holds a word, compares it, and shifts with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell import bdq_pkg::*; (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  occupied,
  input  wire logic                  tail,
  input  wire logic [WORD_WIDTH-1:0] left_word,
  input  wire logic [WORD_WIDTH-1:0] right_word,
  input  wire logic                  hit_in,
  output logic      [WORD_WIDTH-1:0] word,
  output logic                       hit_out
);

  logic                  match;
  logic [WORD_WIDTH-1:0] word_next;

  assign match   = occupied && (word == ctrl.value);
  assign hit_out = hit_in || match;

  always_comb begin
    case (ctrl.cmd)
      CMD_PUSH_FRONT: word_next = left_word;
      CMD_PUSH_BACK:  word_next = tail ? ctrl.value : word;
      CMD_POP_FRONT:  word_next = right_word;
      CMD_REMOVE:     word_next = hit_out ? right_word : word;
      default:        word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

/* tb/bounded_deque_with_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_checker
// Watches the request and response channels of the deque. It keeps its own
// copy of the stored words, works out the deque view that each accepted
// request leads to, and compares every accepted response with the oldest
// view still due, field by field. It reports the failure count and the
// number of responses still due.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_checker import bdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  bdq_req_if   req,
  bdq_rsp_if   rsp,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    status_t                      status;
    logic                         found;
    logic        [COUNT_W-1:0]    entry_count;
    logic signed [WORD_WIDTH-1:0] front_value;
    logic signed [WORD_WIDTH-1:0] back_value;
  } deque_view_t;

  logic signed [WORD_WIDTH-1:0] words_held [CAPACITY];
  int                           held_count;
  deque_view_t                  views_due [$];

  function automatic deque_view_t advance_deque(logic [KIND_W-1:0] kind,
                                                logic signed [WORD_WIDTH-1:0] value);
    deque_view_t view;
    int          hit;
    view = '0;
    view.status = ST_OK;
    hit = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && words_held[i] == value) hit = i;
    end
    case (kind)
      K_PUSH_FRONT: begin
        if (held_count >= CAPACITY) begin
          view.status = ST_OVERFLOW;
        end else begin
          for (int i = held_count; i > 0; i--) words_held[i] = words_held[i-1];
          words_held[0] = value;
          held_count++;
        end
      end
      K_PUSH_BACK: begin
        if (held_count >= CAPACITY) begin
          view.status = ST_OVERFLOW;
        end else begin
          words_held[held_count] = value;
          held_count++;
        end
      end
      K_POP_FRONT: begin
        if (held_count == 0) begin
          view.status = ST_UNDERFLOW;
        end else begin
          for (int i = 0; i < held_count - 1; i++) words_held[i] = words_held[i+1];
          held_count--;
        end
      end
      K_POP_BACK: begin
        if (held_count == 0) view.status = ST_UNDERFLOW;
        else held_count--;
      end
      K_CONTAINS: begin
        view.found = (hit >= 0);
      end
      K_REMOVE: begin
        if (hit < 0) begin
          view.status = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i < held_count - 1; i++) words_held[i] = words_held[i+1];
          held_count--;
          view.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    view.entry_count = held_count[COUNT_W-1:0];
    if (held_count > 0) begin
      view.front_value = words_held[0];
      view.back_value  = words_held[held_count-1];
    end
    return view;
  endfunction

  function automatic void compare_field(string field, logic [WORD_WIDTH-1:0] want,
                                        logic [WORD_WIDTH-1:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    deque_view_t want;
    if (rst) begin
      held_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (views_due.size() == 0) begin
          failures++;
          if (failures <= 40)
            $display("%0t: response with none due, expected nothing, actual %0h %0h %0h %0h %0h",
                     $time, rsp.status, rsp.found, rsp.entry_count, rsp.front_value,
                     rsp.back_value);
        end else begin
          want = views_due.pop_front();
          compare_field("status", want.status, rsp.status);
          compare_field("found", want.found, rsp.found);
          compare_field("entry_count", want.entry_count, rsp.entry_count);
          compare_field("front_value", want.front_value, rsp.front_value);
          compare_field("back_value", want.back_value, rsp.back_value);
        end
      end
      if (req.valid && req.ready) views_due.push_back(advance_deque(req.kind, req.value));
    end
    outstanding = views_due.size();
  end

endmodule

/* tb/bounded_deque_with_search_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_search_test
// Drives requests into the deque: a directed opening on the empty and
// partly filled deque, then random fill, drain and mixed runs that reach
// the full and empty limits, with duplicate words for search and removal.
// Sender and receiver idle at random in the first two phases, not in the
// third; the checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_test;
  import bdq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = ~WORD_MIN;
  localparam int REQUESTS_PER_PHASE = 534;

  logic clk;
  logic rst;
  int   failures;
  int   outstanding;
  int   gap_pct;
  int   stall_pct;
  int   kind_cuts [3][6] = '{'{35, 70, 78, 84, 92, 98},
                             '{8, 16, 45, 72, 82, 96},
                             '{15, 30, 45, 60, 75, 95}};
  logic signed [WORD_WIDTH-1:0] word_pool [8];

  bdq_req_if req ();
  bdq_rsp_if rsp ();

  bounded_deque_with_search dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bounded_deque_with_search_checker deque_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send(input logic [KIND_W-1:0] kind, input logic signed [WORD_WIDTH-1:0] value);
    while ($urandom_range(0, 99) < gap_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.value <= value;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
  endtask

  // hold off until every response has come back
  task automatic drain_results();
    req.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [KIND_W-1:0]            kind;
    logic signed [WORD_WIDTH-1:0] value;
    int                           mode;
    int                           roll;
    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.kind  <= K_PUSH_FRONT;
    req.value <= '0;
    gap_pct   = 34;
    stall_pct = 75;
    mode      = 0;
    word_pool = '{'0, '1, WORD_MIN, WORD_MAX, 1, $urandom, $urandom, $urandom};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty deque
    send(K_POP_FRONT, '0);
    send(K_POP_BACK, '0);
    send(K_CONTAINS, '0);
    send(K_REMOVE, '0);
    send(KIND_SPARE_LO, WORD_MAX);
    send(KIND_SPARE_HI, WORD_MIN);
    // extremes, duplicates, alternating bits
    send(K_PUSH_BACK, WORD_MAX);
    send(K_PUSH_FRONT, WORD_MIN);
    send(K_PUSH_BACK, '0);
    send(K_PUSH_FRONT, '1);
    send(K_PUSH_BACK, WORD_MAX);
    send(K_PUSH_BACK, 32'hAAAA_AAAA);
    send(K_PUSH_FRONT, 32'h5555_5555);
    send(K_CONTAINS, WORD_MIN);
    send(K_CONTAINS, 32'd12345);
    send(K_REMOVE, WORD_MAX);
    send(K_REMOVE, 32'h5555_5555);
    send(K_REMOVE, 32'h1234_5678);
    send(KIND_SPARE_LO, '0);
    send(K_POP_FRONT, '0);
    send(K_POP_BACK, '0);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 34;
          stall_pct = 75;
        end
        1: begin
          gap_pct   = 75;
          stall_pct = 34;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        if (n % 24 == 0) mode = $urandom_range(0, 2);
        roll = $urandom_range(0, 99);
        kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        for (int j = 5; j >= 0; j--) begin
          if (roll < kind_cuts[mode][j]) kind = kind_t'(j);
        end
        roll = $urandom_range(0, 9);
        if (roll < 6) value = word_pool[$urandom_range(0, 7)];
        else if (roll == 6) value = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
        else value = $urandom;
        send(kind, value);
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("[bounded_deque_with_search] OK");
    end else begin
      $display("[bounded_deque_with_search] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[bounded_deque_with_search] ERROR");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_req_if.sv
hw/rtl/bdq_rsp_if.sv
hw/rtl/bdq_cell.sv
hw/rtl/bounded_deque_with_search.sv
tb/bounded_deque_with_search_checker.sv
tb/bounded_deque_with_search_test.sv
